FILE: rtl/core/ssw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssw_pkg;

  // default sizes
  localparam int MAX_WAVES_DEF  = 4;
  localparam int SINE_DEPTH_DEF = 256;
  localparam int WORD_SLOTS     = 4;

  // field widths
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int COUNT_W    = 3;
  localparam int POS_W      = 24;
  localparam int TIME_W     = 32;
  localparam int HEIGHT_W   = 20;
  localparam int PHASE_W    = 32;
  localparam int DIR_W      = 12;
  localparam int AMP_W      = 12;
  localparam int FREQ_W     = 14;
  localparam int SINE_W     = 15;
  localparam int TERM_W     = 16;
  localparam int SUM_W      = 23;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_COUNT  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_A      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_B      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_C      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAVE_D      = 3'd5;

  // pi/2 in Q2.30
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  localparam logic signed [SUM_W-1:0] HEIGHT_MAX = 23'sd524287;
  localparam logic signed [SUM_W-1:0] HEIGHT_MIN = -23'sd524288;

  // one packed wave word, msb first
  typedef struct packed {
    logic [FREQ_W-1:0]       temporal_freq;
    logic [FREQ_W-1:0]       spatial_freq;
    logic [AMP_W-1:0]        amplitude;
    logic signed [DIR_W-1:0] dir_z;
    logic signed [DIR_W-1:0] dir_x;
  } wave_word_t;

endpackage

`default_nettype wire

FILE: rtl/core/ssw_phase.sv
`timescale 1ns / 1ps
`default_nettype none

module ssw_phase #(
  parameter int MAX_WAVES        = ssw_pkg::MAX_WAVES_DEF,
  parameter int SINE_TABLE_DEPTH = ssw_pkg::SINE_DEPTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  logic signed [ssw_pkg::POS_W-1:0]                  pos_x,
  input  logic signed [ssw_pkg::POS_W-1:0]                  pos_z,
  input  logic [ssw_pkg::TIME_W-1:0]                        sim_time,
  input  ssw_pkg::wave_word_t [MAX_WAVES-1:0]               words,
  output logic                                              out_valid,
  output logic [MAX_WAVES-1:0]                              out_neg,
  output logic [MAX_WAVES-1:0][$clog2(SINE_TABLE_DEPTH+1)-1:0] out_addr
);

  localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int FRAC_W = ssw_pkg::PHASE_W - 2;
  localparam int TPROD_W = ssw_pkg::PHASE_W - 6;
  localparam logic [IDX_W-1:0] DEPTH_V = IDX_W'(SINE_TABLE_DEPTH);

  logic                                 v1;
  logic                                 v2;
  logic [MAX_WAVES-1:0][ssw_pkg::PHASE_W-1:0] prod_x;
  logic [MAX_WAVES-1:0][ssw_pkg::PHASE_W-1:0] prod_z;
  logic [MAX_WAVES-1:0][TPROD_W-1:0]          tprod;
  logic [MAX_WAVES-1:0][ssw_pkg::PHASE_W-1:0] spatial;
  logic [MAX_WAVES-1:0][ssw_pkg::PHASE_W-1:0] temporal;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  for (genvar w = 0; w < MAX_WAVES; w++) begin : g_lane
    logic signed [ssw_pkg::DIR_W+ssw_pkg::POS_W-1:0] px_full;
    logic signed [ssw_pkg::DIR_W+ssw_pkg::POS_W-1:0] pz_full;
    logic [TPROD_W+ssw_pkg::FREQ_W-1:0]              t_full;
    logic [ssw_pkg::PHASE_W-1:0]                     dot;
    logic [ssw_pkg::PHASE_W+ssw_pkg::FREQ_W-1:0]     sp_full;
    logic [ssw_pkg::PHASE_W-1:0]                     phase;
    logic [FRAC_W+IDX_W-1:0]                         idx_full;
    logic [IDX_W-1:0]                                idx;

    // stage 1: direction and time products
    assign px_full = words[w].dir_x * pos_x;
    assign pz_full = words[w].dir_z * pos_z;
    assign t_full  = sim_time[TPROD_W-1:0] * words[w].temporal_freq;

    // stage 2: dot product times spatial frequency, modulo one turn
    assign dot     = prod_x[w] + prod_z[w];
    assign sp_full = dot * words[w].spatial_freq;

    // stage 3: quadrant fold into the quarter-wave table address
    assign phase    = spatial[w] - temporal[w];
    assign idx_full = phase[FRAC_W-1:0] * DEPTH_V;
    assign idx      = idx_full[FRAC_W+IDX_W-1:FRAC_W];

    always_ff @(posedge clk) begin
      prod_x[w]   <= px_full[ssw_pkg::PHASE_W-1:0];
      prod_z[w]   <= pz_full[ssw_pkg::PHASE_W-1:0];
      tprod[w]    <= t_full[TPROD_W-1:0];
      spatial[w]  <= sp_full[ssw_pkg::PHASE_W-1:0];
      temporal[w] <= {tprod[w], 6'b0};
      out_neg[w]  <= phase[ssw_pkg::PHASE_W-1];
      out_addr[w] <= phase[ssw_pkg::PHASE_W-2] ? (DEPTH_V - idx) : idx;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssw_sine.sv
`timescale 1ns / 1ps
`default_nettype none

module ssw_sine #(
  parameter int MAX_WAVES        = ssw_pkg::MAX_WAVES_DEF,
  parameter int SINE_TABLE_DEPTH = ssw_pkg::SINE_DEPTH_DEF
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              in_valid,
  input  logic [MAX_WAVES-1:0]                              in_neg,
  input  logic [MAX_WAVES-1:0][$clog2(SINE_TABLE_DEPTH+1)-1:0] in_addr,
  input  ssw_pkg::wave_word_t [MAX_WAVES-1:0]               words,
  output logic                                              out_valid,
  output logic signed [MAX_WAVES-1:0][ssw_pkg::TERM_W-1:0]  out_term
);

  localparam int PROD_W = ssw_pkg::AMP_W + ssw_pkg::SINE_W;

  // quarter-wave sine, Q1.14, by integer Taylor series in Q2.30
  function automatic logic [ssw_pkg::SINE_W-1:0] gen_sine(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        rnd;
    x    = (ssw_pkg::HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    sum  = $signed(x);
    for (int n = 1; n < 16; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) sum = sum - $signed(term);
      else sum = sum + $signed(term);
    end
    if (sum < 0) sum = 0;
    rnd = 64'(sum) + 64'h8000;
    return rnd[16+ssw_pkg::SINE_W-1:16];
  endfunction

  logic [ssw_pkg::SINE_W-1:0] sine_tab [0:SINE_TABLE_DEPTH];

  for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_tab
    assign sine_tab[g] = gen_sine(g);
  end

  logic                                        v4;
  logic [MAX_WAVES-1:0]                        neg4;
  logic [MAX_WAVES-1:0][ssw_pkg::SINE_W-1:0]   mag;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v4        <= in_valid;
      out_valid <= v4;
    end
  end

  for (genvar w = 0; w < MAX_WAVES; w++) begin : g_lane
    logic [PROD_W-1:0]                scaled;
    logic [ssw_pkg::SINE_W-1:0]       r;
    logic signed [ssw_pkg::TERM_W-1:0] r_s;

    // round half away from zero: scale the magnitude, then apply the sign
    assign scaled = words[w].amplitude * mag[w] + PROD_W'(2048);
    assign r      = scaled[12+ssw_pkg::SINE_W-1:12];
    assign r_s    = $signed({1'b0, r});

    always_ff @(posedge clk) begin
      mag[w]      <= sine_tab[in_addr[w]];
      neg4[w]     <= in_neg[w];
      out_term[w] <= neg4[w] ? -r_s : r_s;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/ssw_accum.sv
`timescale 1ns / 1ps
`default_nettype none

module ssw_accum #(
  parameter int MAX_WAVES = ssw_pkg::MAX_WAVES_DEF
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             in_valid,
  input  logic signed [MAX_WAVES-1:0][ssw_pkg::TERM_W-1:0] in_term,
  input  logic [ssw_pkg::COUNT_W-1:0]                      wave_count,
  input  logic signed [ssw_pkg::HEIGHT_W-1:0]              base_height,
  output logic                                             out_valid,
  output logic signed [ssw_pkg::HEIGHT_W-1:0]              out_height
);

  logic                             v6;
  logic signed [ssw_pkg::SUM_W-1:0] sum;
  logic signed [ssw_pkg::SUM_W-1:0] sum_next;

  // waves from the first word up to the enabled count
  // lane slices of a packed array are unsigned, so sign them before extending
  always_comb begin
    sum_next = ssw_pkg::SUM_W'(base_height);
    for (int w = 0; w < MAX_WAVES; w++) begin
      if (wave_count > ssw_pkg::COUNT_W'(w))
        sum_next = sum_next + ssw_pkg::SUM_W'($signed(in_term[w]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v6        <= in_valid;
      out_valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    sum <= sum_next;
    if (sum > ssw_pkg::HEIGHT_MAX) out_height <= ssw_pkg::HEIGHT_MAX[ssw_pkg::HEIGHT_W-1:0];
    else if (sum < ssw_pkg::HEIGHT_MIN)
      out_height <= ssw_pkg::HEIGHT_MIN[ssw_pkg::HEIGHT_W-1:0];
    else out_height <= sum[ssw_pkg::HEIGHT_W-1:0];
  end

endmodule

`default_nettype wire

FILE: rtl/core/sum_of_sines_wave_height_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// sum-of-sines water height unit
//
// a query (pos_x, pos_z, sim_time) is taken at every clock edge where start
// is high; busy is always low, so a new query may enter every cycle
// each query gives one transaction on the result side: done is high for one
// cycle with surface_height valid in that same cycle
// each query passes all seven register stages below before done goes high;
// throughput is one query per cycle
// the pipeline has seven register stages: position/time products, spatial
// phase product, quadrant fold and table address, sine table read,
// amplitude scaling, wave sum, saturation
// configuration goes through cfg_wr_en / cfg_index / cfg_wdata and takes
// effect at once; write it only while no query is in flight
// reset clears all valid bits and the configuration to zero (no waves,
// base height zero); the receiver cannot stall, results are never held
module sum_of_sines_wave_height_unit #(
  parameter int MAX_WAVES        = ssw_pkg::MAX_WAVES_DEF,
  parameter int SINE_TABLE_DEPTH = ssw_pkg::SINE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [ssw_pkg::POS_W-1:0]      pos_x,
  input  logic signed [ssw_pkg::POS_W-1:0]      pos_z,
  input  logic [ssw_pkg::TIME_W-1:0]            sim_time,
  input  logic                                  cfg_wr_en,
  input  logic [ssw_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ssw_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  output logic                                  done,
  output logic signed [ssw_pkg::HEIGHT_W-1:0]   surface_height
);

  localparam int IDX_W = $clog2(SINE_TABLE_DEPTH + 1);

  // configuration registers
  logic [ssw_pkg::COUNT_W-1:0]          wave_count;
  logic signed [ssw_pkg::HEIGHT_W-1:0]  base_height;
  ssw_pkg::wave_word_t                  wave_words [ssw_pkg::WORD_SLOTS];

  // lanes see the first MAX_WAVES words
  ssw_pkg::wave_word_t [MAX_WAVES-1:0]  lane_words;

  // phase stage to sine stage
  logic                                 ph_valid;
  logic [MAX_WAVES-1:0]                 ph_neg;
  logic [MAX_WAVES-1:0][IDX_W-1:0]      ph_addr;

  // sine stage to sum stage
  logic                                             sn_valid;
  logic signed [MAX_WAVES-1:0][ssw_pkg::TERM_W-1:0] sn_term;

  // the pipeline never stalls
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      wave_count  <= '0;
      base_height <= '0;
      for (int i = 0; i < ssw_pkg::WORD_SLOTS; i++) wave_words[i] <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        ssw_pkg::REG_WAVE_COUNT:  wave_count  <= cfg_wdata[ssw_pkg::COUNT_W-1:0];
        ssw_pkg::REG_BASE_HEIGHT: base_height <= cfg_wdata[ssw_pkg::HEIGHT_W-1:0];
        ssw_pkg::REG_WAVE_A:      wave_words[0] <= cfg_wdata;
        ssw_pkg::REG_WAVE_B:      wave_words[1] <= cfg_wdata;
        ssw_pkg::REG_WAVE_C:      wave_words[2] <= cfg_wdata;
        ssw_pkg::REG_WAVE_D:      wave_words[3] <= cfg_wdata;
        default: ; // unknown index, write dropped
      endcase
    end
  end

  for (genvar w = 0; w < MAX_WAVES; w++) begin : g_words
    assign lane_words[w] = wave_words[w];
  end

  // stages 1 to 3: phase in turns, folded to a table address
  ssw_phase #(
    .MAX_WAVES        (MAX_WAVES),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_phase (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (start && !busy),
    .pos_x     (pos_x),
    .pos_z     (pos_z),
    .sim_time  (sim_time),
    .words     (lane_words),
    .out_valid (ph_valid),
    .out_neg   (ph_neg),
    .out_addr  (ph_addr)
  );

  // stages 4 and 5: table read and amplitude scaling
  ssw_sine #(
    .MAX_WAVES        (MAX_WAVES),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_sine (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ph_valid),
    .in_neg    (ph_neg),
    .in_addr   (ph_addr),
    .words     (lane_words),
    .out_valid (sn_valid),
    .out_term  (sn_term)
  );

  // stages 6 and 7: sum of enabled waves and saturation
  ssw_accum #(
    .MAX_WAVES (MAX_WAVES)
  ) u_accum (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sn_valid),
    .in_term     (sn_term),
    .wave_count  (wave_count),
    .base_height (base_height),
    .out_valid   (done),
    .out_height  (surface_height)
  );

  // every query is followed by a result on done
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |=> ##6 done)
    else $error("query lost in pipeline");

  // no result without a matching earlier query
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 7))
    else $error("result without query");

  // reset clears the result strobe
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe after reset");

endmodule

`default_nettype wire
